// ----- hw/rtl/cps_pkg.sv -----
// shared widths and the side payload type of the circle pair separation pipeline
package cps_pkg;

	localparam int COORD_W = 32;
	localparam int RAD_W   = 24;
	localparam int MASS_W  = 16;
	localparam int RSUM_W  = RAD_W + 1;
	localparam int SQ_W    = 2 * RSUM_W;
	localparam int TOT_W   = MASS_W + 1;
	localparam int PROD_W  = RSUM_W + MASS_W;

	typedef struct packed {
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
		logic [RSUM_W-1:0]  rsum;
		logic [RSUM_W-1:0]  adx;
		logic [RSUM_W-1:0]  ady;
		logic               sx;
		logic               sy;
		logic [MASS_W-1:0]  m1;
		logic [MASS_W-1:0]  m2;
		logic               hit;
		logic               zero;
	} cps_side_t;

endpackage

// ----- hw/rtl/cps_isqrt.sv -----
// pipelined integer square root, one root bit per stage, with side payload
module cps_isqrt #(
	parameter int RW = 25,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] in_value,
	input  logic [PW-1:0]   in_pay,
	output logic            out_valid,
	output logic [RW-1:0]   out_root,
	output logic [PW-1:0]   out_pay
);

	logic            vld_s  [0:RW];
	logic [2*RW-1:0] v_s    [0:RW];
	logic [RW:0]     rem_s  [0:RW];
	logic [RW-1:0]   root_s [0:RW];
	logic [PW-1:0]   pay_s  [0:RW];

	assign vld_s[0]  = in_valid;
	assign v_s[0]    = in_value;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign pay_s[0]  = in_pay;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [RW+2:0] rem_sh;
		logic [RW+2:0] trial;
		logic          ge;

		// bring down the next two radicand bits and try root*4+1
		assign rem_sh = {rem_s[k], v_s[k][2*RW-1 -: 2]};
		assign trial  = {1'b0, root_s[k], 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
				root_s[k+1] <= {root_s[k][RW-2:0], ge};
				v_s[k+1]    <= v_s[k] << 2;
				pay_s[k+1]  <= pay_s[k];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign out_root  = root_s[RW];
	assign out_pay   = pay_s[RW];

endmodule

// ----- hw/rtl/cps_div.sv -----
// pipelined rounded division of several lanes by one shared divisor
module cps_div #(
	parameter int LN = 2,
	parameter int NW = 50,
	parameter int DW = 25,
	parameter int QW = 25,
	parameter int PW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [LN-1:0][NW-1:0] num,
	input  logic [DW-1:0]         den,
	input  logic [PW-1:0]         in_pay,
	output logic                  out_valid,
	output logic [LN-1:0][QW-1:0] quo,
	output logic [PW-1:0]         out_pay
);

	localparam int REM_W = NW + 1;
	localparam int CW    = (REM_W > DW + QW) ? REM_W : DW + QW;

	logic                     vld_s [0:QW];
	logic [LN-1:0][REM_W-1:0] rem_s [0:QW];
	logic [LN-1:0][QW-1:0]    q_s   [0:QW];
	logic [DW-1:0]            den_s [0:QW];
	logic [PW-1:0]            pay_s [0:QW];

	// first stage adds half the divisor so the quotient rounds half away from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LN; l++) begin
				rem_s[0][l] <= {1'b0, num[l]} + REM_W'(den >> 1);
			end
			q_s[0]   <= '0;
			den_s[0] <= den;
			pay_s[0] <= in_pay;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [CW-1:0]            dsh;
		logic [LN-1:0]            ge;
		logic [LN-1:0][REM_W-1:0] rem_nx;
		logic [LN-1:0][QW-1:0]    q_nx;

		assign dsh = CW'(den_s[k]) << (QW - 1 - k);

		always_comb begin
			for (int l = 0; l < LN; l++) begin
				ge[l]     = CW'(rem_s[k][l]) >= dsh;
				rem_nx[l] = ge[l] ? REM_W'(CW'(rem_s[k][l]) - dsh) : rem_s[k][l];
				q_nx[l]   = {q_s[k][l][QW-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_nx;
				q_s[k+1]   <= q_nx;
				den_s[k+1] <= den_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = q_s[QW];
	assign out_pay   = pay_s[QW];

endmodule

// ----- hw/rtl/circle_pair_separation.sv -----
// top level: mass-weighted separation of two overlapping circles
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, first_*, second_*      | request in
//  output  | out_valid, out_stall, new_*, overlapped    | result out
//
// one request enters per cycle while in_stall is low; each result passes through the
// 25-stage square root and the two 26-stage rounded dividers in the pipeline.
// reset clears only the valid bits of every stage.
// a stalled result freezes the whole pipeline, so nothing is lost or repeated;
// in_stall is high exactly while a result waits under out_stall.
module circle_pair_separation (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [cps_pkg::COORD_W-1:0] first_x,
	input  logic [cps_pkg::COORD_W-1:0] first_y,
	input  logic [cps_pkg::RAD_W-1:0]   first_radius,
	input  logic [cps_pkg::MASS_W-1:0]  first_mass,
	input  logic [cps_pkg::COORD_W-1:0] second_x,
	input  logic [cps_pkg::COORD_W-1:0] second_y,
	input  logic [cps_pkg::RAD_W-1:0]   second_radius,
	input  logic [cps_pkg::MASS_W-1:0]  second_mass,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cps_pkg::COORD_W-1:0] new_first_x,
	output logic [cps_pkg::COORD_W-1:0] new_first_y,
	output logic [cps_pkg::COORD_W-1:0] new_second_x,
	output logic [cps_pkg::COORD_W-1:0] new_second_y,
	output logic                       overlapped
);

	import cps_pkg::*;

	// add a signed push to a base position and clamp to the 32-bit range
	function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] b,
			input logic [RSUM_W-1:0] a, input logic neg);
		logic [COORD_W+1:0] e;
		logic [COORD_W+1:0] v;
		e = {{(COORD_W+2-RSUM_W){1'b0}}, a};
		v = {{2{b[COORD_W-1]}}, b} + (neg ? -e : e);
		if (v[COORD_W+1:COORD_W-1] == 3'b000 || v[COORD_W+1:COORD_W-1] == 3'b111) begin
			return v[COORD_W-1:0];
		end else if (v[COORD_W+1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	logic            v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	cps_side_t       side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	cps_side_t       side_s8, side_s9;
	logic [COORD_W:0] dx_s1, dy_s1;
	logic [COORD_W:0] adx_s2, ady_s2;
	logic            near_s3, near_s4;
	logic [SQ_W-1:0] sqx_s3, sqy_s3, rs2_s3, rs2_s4;
	logic [SQ_W:0]   d2_s4;
	logic [SQ_W-1:0] d2_s5;
	logic [RSUM_W-1:0] pen_s6, den_s6, den_s7;
	logic [1:0][SQ_W-1:0] prod_s7;
	logic [1:0][RSUM_W-1:0] pm_s8;
	logic [TOT_W-1:0] tot_s8, tot_s9;
	logic [3:0][PROD_W-1:0] prod_s9;

	logic [COORD_W-1:0] new_first_x_q, new_first_y_q, new_second_x_q, new_second_y_q;
	logic               overlapped_q;

	logic            vr, vd1, vd2;
	logic [RSUM_W-1:0] root;
	cps_side_t       side_r, side_d1, side_d2;
	logic [1:0][RSUM_W-1:0] q1;
	logic [3:0][RSUM_W-1:0] q2;

	cps_side_t       side_in, side_mag, side_flag;

	logic            both_zero;
	assign both_zero = (first_mass == '0) && (second_mass == '0);

	// centre positions, radius sum, mass fix-up
	always_comb begin
		side_in      = '0;
		side_in.x1   = first_x;
		side_in.y1   = first_y;
		side_in.x2   = second_x;
		side_in.y2   = second_y;
		side_in.rsum = {1'b0, first_radius} + {1'b0, second_radius};
		side_in.m1   = both_zero ? MASS_W'(1) : first_mass;
		side_in.m2   = both_zero ? MASS_W'(1) : second_mass;
	end

	always_comb begin
		side_mag     = side_s1;
		side_mag.sx  = dx_s1[COORD_W];
		side_mag.sy  = dy_s1[COORD_W];
		side_mag.adx = RSUM_W'(dx_s1[COORD_W] ? -dx_s1 : dx_s1);
		side_mag.ady = RSUM_W'(dy_s1[COORD_W] ? -dy_s1 : dy_s1);
	end

	// overlap and coincident-centre flags
	always_comb begin
		side_flag      = side_s4;
		side_flag.hit  = near_s4 && (d2_s4 < {1'b0, rs2_s4});
		side_flag.zero = d2_s4 == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= vr;
			v_s7        <= v_s6;
			v_s8        <= vd1;
			v_s9        <= v_s8;
			out_valid_q <= vd2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// centre differences
			dx_s1   <= {first_x[COORD_W-1], first_x} - {second_x[COORD_W-1], second_x};
			dy_s1   <= {first_y[COORD_W-1], first_y} - {second_y[COORD_W-1], second_y};
			side_s1 <= side_in;

			// magnitudes
			adx_s2  <= dx_s1[COORD_W] ? -dx_s1 : dx_s1;
			ady_s2  <= dy_s1[COORD_W] ? -dy_s1 : dy_s1;
			side_s2 <= side_mag;

			// far-apart test and squares
			near_s3 <= (adx_s2 < (COORD_W+1)'(side_s2.rsum)) &&
				(ady_s2 < (COORD_W+1)'(side_s2.rsum));
			sqx_s3  <= SQ_W'(side_s2.adx) * SQ_W'(side_s2.adx);
			sqy_s3  <= SQ_W'(side_s2.ady) * SQ_W'(side_s2.ady);
			rs2_s3  <= SQ_W'(side_s2.rsum) * SQ_W'(side_s2.rsum);
			side_s3 <= side_s2;

			d2_s4   <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
			rs2_s4  <= rs2_s3;
			near_s4 <= near_s3;
			side_s4 <= side_s3;

			d2_s5   <= d2_s4[SQ_W-1:0];
			side_s5 <= side_flag;

			// penetration depth
			pen_s6  <= side_r.rsum - root;
			den_s6  <= (root == '0) ? RSUM_W'(1) : root;
			side_s6 <= side_r;

			prod_s7[0] <= SQ_W'(side_s6.adx) * SQ_W'(pen_s6);
			prod_s7[1] <= SQ_W'(side_s6.ady) * SQ_W'(pen_s6);
			den_s7     <= den_s6;
			side_s7    <= side_s6;

			// push magnitudes; coincident centres push apart along y, the first towards +y, by the radius sum
			pm_s8[0] <= side_d1.zero ? '0 : q1[0];
			pm_s8[1] <= side_d1.zero ? side_d1.rsum : q1[1];
			tot_s8   <= {1'b0, side_d1.m1} + {1'b0, side_d1.m2};
			side_s8  <= side_d1;

			prod_s9[0] <= PROD_W'(pm_s8[0]) * PROD_W'(side_s8.m2);
			prod_s9[1] <= PROD_W'(pm_s8[1]) * PROD_W'(side_s8.m2);
			prod_s9[2] <= PROD_W'(pm_s8[0]) * PROD_W'(side_s8.m1);
			prod_s9[3] <= PROD_W'(pm_s8[1]) * PROD_W'(side_s8.m1);
			tot_s9     <= tot_s8;
			side_s9    <= side_s8;

			new_first_x_q  <= side_d2.hit ? sat_add(side_d2.x1, q2[0], side_d2.sx) :
				side_d2.x1;
			new_first_y_q  <= side_d2.hit ? sat_add(side_d2.y1, q2[1], side_d2.sy) :
				side_d2.y1;
			new_second_x_q <= side_d2.hit ? sat_add(side_d2.x2, q2[2], !side_d2.sx) :
				side_d2.x2;
			new_second_y_q <= side_d2.hit ? sat_add(side_d2.y2, q2[3], !side_d2.sy) :
				side_d2.y2;
			overlapped_q   <= side_d2.hit;
		end
	end

	cps_isqrt #(
		.RW(RSUM_W),
		.PW($bits(cps_side_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s5),
		.in_value (d2_s5),
		.in_pay   (side_s5),
		.out_valid(vr),
		.out_root (root),
		.out_pay  (side_r)
	);

	cps_div #(
		.LN(2),
		.NW(SQ_W),
		.DW(RSUM_W),
		.QW(RSUM_W),
		.PW($bits(cps_side_t))
	) u_div_push (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s7),
		.num      (prod_s7),
		.den      (den_s7),
		.in_pay   (side_s7),
		.out_valid(vd1),
		.quo      (q1),
		.out_pay  (side_d1)
	);

	cps_div #(
		.LN(4),
		.NW(PROD_W),
		.DW(TOT_W),
		.QW(RSUM_W),
		.PW($bits(cps_side_t))
	) u_div_share (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s9),
		.num      (prod_s9),
		.den      (tot_s9),
		.in_pay   (side_s9),
		.out_valid(vd2),
		.quo      (q2),
		.out_pay  (side_d2)
	);

	assign out_valid    = out_valid_q;
	assign new_first_x  = new_first_x_q;
	assign new_first_y  = new_first_y_q;
	assign new_second_x = new_second_x_q;
	assign new_second_y = new_second_y_q;
	assign overlapped   = overlapped_q;

endmodule
